>>> src/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/lfu_pkg.sv
// Shared types, constants and helpers of the LFU frame table.
package lfu_pkg;

  localparam int CNT_W    = 32;
  localparam int CFG_W    = 5;
  localparam int PAGE_IN_W = 16;
  localparam int FRAME_OUT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Search status handed from cell to cell
  typedef struct packed {
    logic vld;        // search token present at this stage
    logic hit;        // a matching frame has been found
    logic empty;      // an empty active frame has been found
    logic have_best;  // a victim candidate has been recorded
  } srch_flags_t;

  // Update command broadcast to the cells
  typedef struct packed {
    logic en;    // update the addressed cell
    logic fill;  // load a new page (miss) instead of bumping the count (hit)
  } cell_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> src/lfu_cell.sv
// One frame of the table: holds page, valid, use count and stamp; one stage of the search chain.
module lfu_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = 16,
  parameter int IW        = 4,
  parameter int NW        = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic [NW-1:0]             n_eff,
  input  logic [PAGE_BITS-1:0]      look_page,
  input  lfu_pkg::srch_flags_t      flg_i,
  input  logic [IW-1:0]             hit_idx_i,
  input  logic [IW-1:0]             empty_idx_i,
  input  logic [IW-1:0]             best_idx_i,
  input  logic [lfu_pkg::CNT_W-1:0] best_cnt_i,
  input  logic [lfu_pkg::CNT_W-1:0] best_stamp_i,
  input  logic [PAGE_BITS-1:0]      best_page_i,
  output lfu_pkg::srch_flags_t      flg_o,
  output logic [IW-1:0]             hit_idx_o,
  output logic [IW-1:0]             empty_idx_o,
  output logic [IW-1:0]             best_idx_o,
  output logic [lfu_pkg::CNT_W-1:0] best_cnt_o,
  output logic [lfu_pkg::CNT_W-1:0] best_stamp_o,
  output logic [PAGE_BITS-1:0]      best_page_o,
  input  lfu_pkg::cell_wr_t         wr,
  input  logic [IW-1:0]             wr_idx,
  input  logic [PAGE_BITS-1:0]      wr_page,
  input  logic [lfu_pkg::CNT_W-1:0] wr_time
);
  import lfu_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [NW-1:0] MY_POS = NW'(IDX);

  logic                 valid_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     stamp_r;

  logic active;
  logic is_hit;
  logic is_empty;
  logic is_better;
  logic sel;

  srch_flags_t          flg_nxt;
  logic [IW-1:0]        hit_idx_nxt;
  logic [IW-1:0]        empty_idx_nxt;
  logic [IW-1:0]        best_idx_nxt;
  logic [CNT_W-1:0]     best_cnt_nxt;
  logic [CNT_W-1:0]     best_stamp_nxt;
  logic [PAGE_BITS-1:0] best_page_nxt;

  assign active   = (MY_POS < n_eff);
  assign is_hit   = active && valid_r && (page_r == look_page);
  assign is_empty = active && !valid_r;
  assign is_better = active && (!flg_i.have_best || (cnt_r < best_cnt_i) ||
                     ((cnt_r == best_cnt_i) && (stamp_r < best_stamp_i)));
  assign sel = wr.en && (wr_idx == MY_IDX);

  // Fold this frame into the running search result
  always_comb begin
    flg_nxt        = flg_i;
    hit_idx_nxt    = hit_idx_i;
    empty_idx_nxt  = empty_idx_i;
    best_idx_nxt   = best_idx_i;
    best_cnt_nxt   = best_cnt_i;
    best_stamp_nxt = best_stamp_i;
    best_page_nxt  = best_page_i;
    if (!flg_i.hit && is_hit) begin
      flg_nxt.hit = 1'b1;
      hit_idx_nxt = MY_IDX;
    end
    if (!flg_i.empty && is_empty) begin
      flg_nxt.empty = 1'b1;
      empty_idx_nxt = MY_IDX;
    end
    if (is_better) begin
      flg_nxt.have_best = 1'b1;
      best_idx_nxt      = MY_IDX;
      best_cnt_nxt      = cnt_r;
      best_stamp_nxt    = stamp_r;
      best_page_nxt     = page_r;
    end
  end

  // Hand the search status to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_o <= '0;
    end else begin
      flg_o <= flg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_o    <= hit_idx_nxt;
    empty_idx_o  <= empty_idx_nxt;
    best_idx_o   <= best_idx_nxt;
    best_cnt_o   <= best_cnt_nxt;
    best_stamp_o <= best_stamp_nxt;
    best_page_o  <= best_page_nxt;
  end

  // Drop the frame on a trace restart, mark it on a fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (sel && wr.fill) begin
      valid_r <= 1'b1;
    end
  end

  // Load a new page or bump the use count
  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= wr_time;
      if (wr.fill) begin
        page_r <= wr_page;
        cnt_r  <= CNT_W'(1);
      end else begin
        cnt_r <= sat_inc(cnt_r);
      end
    end
  end

endmodule

>>> src/lfu_page_replacement_lru_tiebreak_top.sv
// LFU frame table with LRU tie-break: a row of frame cells searched one cell per cycle.
// The start transfer launches a search token through launch_r; the result leaving the last cell is registered.
// A new reference is taken only after the previous search is done; the search token walks the cell row.
// busy stays high from the start transfer until the cycle of the result strobe.
// Reset empties every frame, zeroes time and fault count, sets frames_in_use to 16.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lfu_page_replacement_lru_tiebreak_top #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lfu_pkg::PAGE_IN_W-1:0]   in_page,
  input  logic                            in_new_trace,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [lfu_pkg::FRAME_OUT_W-1:0] out_frame,
  output logic                            out_replaced_valid,
  output logic [lfu_pkg::PAGE_IN_W-1:0]   out_replaced_page,
  output logic [lfu_pkg::CNT_W-1:0]       out_fault_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]       cfg_data
);
  import lfu_pkg::*;

`include "assert_macros.svh"

  localparam int IW = $clog2(FRAMES);
  localparam int NW = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

  logic                 busy_r;
  logic                 launch_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     time_r;
  logic [CNT_W-1:0]     faults_r;
  logic [CFG_W-1:0]     fiu_r;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [FRAME_OUT_W-1:0]  out_frame_r;
  logic                    out_repl_r;
  logic [PAGE_IN_W-1:0]    out_repl_page_r;
  logic [CNT_W-1:0]        out_faults_r;

  logic            accept;
  logic            clear;
  logic [NW-1:0]   fiu_ext;
  logic [NW-1:0]   n_eff;
  logic            done;
  logic            miss;
  logic            evict;
  logic [IW-1:0]   sel_idx;
  logic [CNT_W-1:0] faults_nxt;
  cell_wr_t        wr;

  // Search chain between cells; element 0 is fed here, element FRAMES comes back
  srch_flags_t          flg       [FRAMES+1];
  logic [IW-1:0]        hit_idx   [FRAMES+1];
  logic [IW-1:0]        empty_idx [FRAMES+1];
  logic [IW-1:0]        best_idx  [FRAMES+1];
  logic [CNT_W-1:0]     best_cnt  [FRAMES+1];
  logic [CNT_W-1:0]     best_stamp[FRAMES+1];
  logic [PAGE_BITS-1:0] best_page [FRAMES+1];

  assign accept    = start && !busy_r;
  assign clear     = accept && in_new_trace;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Clamp the frame count to 1..FRAMES
  assign fiu_ext = NW'(fiu_r);
  assign n_eff = (fiu_r == '0) ? NW'(1) :
                 (fiu_ext > NW'(FRAMES)) ? NW'(FRAMES) : fiu_ext;

  // Launch an empty search token into the first cell
  always_comb begin
    flg[0]     = '0;
    flg[0].vld = launch_r;
  end
  assign hit_idx[0]    = '0;
  assign empty_idx[0]  = '0;
  assign best_idx[0]   = '0;
  assign best_cnt[0]   = '0;
  assign best_stamp[0] = '0;
  assign best_page[0]  = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lfu_cell #(
      .IDX       (i),
      .PAGE_BITS (PAGE_BITS),
      .IW        (IW),
      .NW        (NW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .clear        (clear),
      .n_eff        (n_eff),
      .look_page    (page_r),
      .flg_i        (flg[i]),
      .hit_idx_i    (hit_idx[i]),
      .empty_idx_i  (empty_idx[i]),
      .best_idx_i   (best_idx[i]),
      .best_cnt_i   (best_cnt[i]),
      .best_stamp_i (best_stamp[i]),
      .best_page_i  (best_page[i]),
      .flg_o        (flg[i+1]),
      .hit_idx_o    (hit_idx[i+1]),
      .empty_idx_o  (empty_idx[i+1]),
      .best_idx_o   (best_idx[i+1]),
      .best_cnt_o   (best_cnt[i+1]),
      .best_stamp_o (best_stamp[i+1]),
      .best_page_o  (best_page[i+1]),
      .wr           (wr),
      .wr_idx       (sel_idx),
      .wr_page      (page_r),
      .wr_time      (time_r)
    );
  end

  // Resolve the token leaving the last cell
  assign done    = flg[FRAMES].vld;
  assign miss    = !flg[FRAMES].hit;
  assign evict   = miss && !flg[FRAMES].empty;
  assign sel_idx = flg[FRAMES].hit   ? hit_idx[FRAMES] :
                   flg[FRAMES].empty ? empty_idx[FRAMES] : best_idx[FRAMES];
  assign faults_nxt = miss ? sat_inc(faults_r) : faults_r;
  assign wr.en   = done;
  assign wr.fill = miss;

  // Control state: busy, launch, time, fault count, frame-count register, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      time_r      <= '0;
      faults_r    <= '0;
      fiu_r       <= CFG_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      launch_r    <= accept;
      out_valid_r <= done;
      if (cfg_valid) begin
        fiu_r <= cfg_data;
      end
      if (accept) begin
        busy_r <= 1'b1;
        if (in_new_trace) begin
          time_r   <= '0;
          faults_r <= '0;
        end
      end else if (done) begin
        busy_r   <= 1'b0;
        time_r   <= sat_inc(time_r);
        faults_r <= faults_nxt;
      end
    end
  end

  // Hold the lookup page for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= PAGE_BITS'(in_page);
    end
  end

  // Register the result for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r       <= !miss;
      out_frame_r     <= FRAME_OUT_W'(sel_idx);
      out_repl_r      <= evict;
      out_repl_page_r <= evict ? PAGE_IN_W'(best_page[FRAMES]) : '0;
      out_faults_r    <= faults_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_frame          = out_frame_r;
  assign out_replaced_valid = out_repl_r;
  assign out_replaced_page  = out_repl_page_r;
  assign out_fault_total    = out_faults_r;

  // Checks
  `ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `ASSERT_NEXT(a_done_strobe, clk, rst_n, done, out_valid)
  `ASSERT_IMPL(a_evict_miss, clk, rst_n, out_valid && out_replaced_valid, !out_hit)

endmodule
